// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the word-delta decoder RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/core/fwd_pkg.sv =====
// Shared types and constants of the word-delta decoder.
// No dependencies; imported by the RTL modules and by the bench.
`default_nettype none

package fwd_pkg;

	// Top two bits of a line word select its meaning.
	localparam logic [1:0] LINE_WORD_COUNT = 2'b00;
	localparam logic [1:0] LINE_WORD_SKIP  = 2'b11;

	// One frame-store write command.
	typedef struct packed {
		logic [15:0] row;
		logic [15:0] column;
		logic [7:0]  pixel_first;
		logic [7:0]  pixel_second;
		logic [7:0]  word_count;
		logic        end_of_chunk;
	} fwd_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/fwd_in_if.sv =====
// Request channel carrying chunk payload bytes into the decoder.
// Depends on nothing but the handshake convention valid/ready.
`default_nettype none

interface fwd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       chunk_start;

	modport source (output valid, output data_byte, output chunk_start, input ready);
	modport sink (input valid, input data_byte, input chunk_start, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fwd_out_if.sv =====
// Request channel carrying frame-store write commands out of the decoder.
// Depends on nothing but the handshake convention valid/ready.
`default_nettype none

interface fwd_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] row;
	logic [15:0] column;
	logic [7:0]  pixel_first;
	logic [7:0]  pixel_second;
	logic [7:0]  word_count;
	logic        end_of_chunk;

	modport source (output valid, output row, output column, output pixel_first,
		output pixel_second, output word_count, output end_of_chunk, input ready);
	modport sink (input valid, input row, input column, input pixel_first,
		input pixel_second, input word_count, input end_of_chunk, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fwd_parser.sv =====
// Byte parser of the word-delta decoder: parse state and the write command
// that the current byte produces. Depends on fwd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fwd_parser
	import fwd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire logic [7:0]  data_byte,
	input  wire logic        chunk_start,
	output logic             res_valid,
	output fwd_result_t      res
);

	typedef enum logic [3:0] {
		PH_LINES_LO, PH_LINES_HI, PH_WORD_LO, PH_WORD_HI, PH_SKIP, PH_COUNT,
		PH_LIT_A, PH_LIT_B, PH_FILL_A, PH_FILL_B, PH_DONE
	} phase_t;

	phase_t      phase_q, phase_d, phase_e;
	logic [15:0] lines_q, lines_d, lines_e;
	logic [15:0] row_q, row_d, row_e;
	logic [15:0] col_q, col_d, col_e;
	logic [15:0] pkts_q, pkts_d, pkts_e;
	logic [7:0]  words_q, words_d, words_e;
	logic [7:0]  held_q, held_d;

	// A chunk start restarts from the reset state before the byte is parsed.
	always_comb begin
		phase_e = chunk_start ? PH_LINES_LO : phase_q;
		lines_e = chunk_start ? 16'd0 : lines_q;
		row_e   = chunk_start ? 16'd0 : row_q;
		col_e   = chunk_start ? 16'd0 : col_q;
		pkts_e  = chunk_start ? 16'd0 : pkts_q;
		words_e = chunk_start ? 8'd0 : words_q;
	end

	always_comb begin
		logic [15:0] word;
		logic [15:0] pkts_dec;
		logic [15:0] lines_dec;
		logic [7:0]  words_dec;
		logic        end_pkt;
		logic        end_ln;
		logic        bare;
		logic        last;

		word      = {data_byte, held_q};
		pkts_dec  = pkts_e - 16'd1;
		lines_dec = lines_e - 16'd1;
		words_dec = words_e - 8'd1;
		end_pkt   = 1'b0;
		end_ln    = 1'b0;
		bare      = 1'b0;
		last      = 1'b0;

		phase_d   = phase_e;
		lines_d   = lines_e;
		row_d     = row_e;
		col_d     = col_e;
		pkts_d    = pkts_e;
		words_d   = words_e;
		held_d    = held_q;
		res_valid = 1'b0;
		res       = '0;

		case (phase_e)
			PH_LINES_LO: begin
				held_d  = data_byte;
				phase_d = PH_LINES_HI;
			end
			PH_LINES_HI: begin
				lines_d = word;
				if (word == 16'd0) begin
					phase_d          = PH_DONE;
					res_valid        = 1'b1;
					res.row          = row_e;
					res.end_of_chunk = 1'b1;
				end else begin
					phase_d = PH_WORD_LO;
				end
			end
			PH_WORD_LO: begin
				held_d  = data_byte;
				phase_d = PH_WORD_HI;
			end
			PH_WORD_HI: begin
				if (word[15:14] == LINE_WORD_SKIP) begin
					// Skip of 65536 minus the word, modulo 65536.
					row_d   = row_e - word;
					phase_d = PH_WORD_LO;
				end else if (word[15:14] != LINE_WORD_COUNT) begin
					phase_d = PH_WORD_LO;
				end else begin
					pkts_d = word;
					if (word == 16'd0) begin
						end_ln = 1'b1;
						bare   = 1'b1;
					end else begin
						phase_d = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				col_d   = col_e + {8'd0, data_byte};
				phase_d = PH_COUNT;
			end
			PH_COUNT: begin
				if (data_byte == 8'd0) begin
					end_pkt = 1'b1;
					bare    = 1'b1;
				end else if (!data_byte[7]) begin
					words_d = data_byte;
					phase_d = PH_LIT_A;
				end else begin
					// Magnitude of a negative count; -128 gives 128.
					words_d = 8'd0 - data_byte;
					phase_d = PH_FILL_A;
				end
			end
			PH_LIT_A: begin
				held_d  = data_byte;
				phase_d = PH_LIT_B;
			end
			PH_LIT_B: begin
				res_valid        = 1'b1;
				res.row          = row_e;
				res.column       = col_e;
				res.pixel_first  = held_q;
				res.pixel_second = data_byte;
				res.word_count   = 8'd1;
				col_d            = col_e + 16'd2;
				words_d          = words_dec;
				if (words_dec == 8'd0) begin
					end_pkt = 1'b1;
				end else begin
					phase_d = PH_LIT_A;
				end
			end
			PH_FILL_A: begin
				held_d  = data_byte;
				phase_d = PH_FILL_B;
			end
			PH_FILL_B: begin
				res_valid        = 1'b1;
				res.row          = row_e;
				res.column       = col_e;
				res.pixel_first  = held_q;
				res.pixel_second = data_byte;
				res.word_count   = words_e;
				col_d            = col_e + {7'd0, words_e, 1'b0};
				words_d          = 8'd0;
				end_pkt          = 1'b1;
			end
			default: begin
				phase_d = phase_e;
			end
		endcase

		if (end_pkt) begin
			pkts_d = pkts_dec;
			if (pkts_dec == 16'd0) begin
				end_ln = 1'b1;
			end else begin
				phase_d = PH_SKIP;
			end
		end

		if (end_ln) begin
			row_d   = row_e + 16'd1;
			col_d   = 16'd0;
			lines_d = lines_dec;
			last    = (lines_dec == 16'd0);
			phase_d = last ? PH_DONE : PH_WORD_LO;
			if (last) begin
				res.end_of_chunk = 1'b1;
				if (bare) begin
					res_valid = 1'b1;
					res.row   = row_e;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LINES_LO;
			lines_q <= '0;
			row_q   <= '0;
			col_q   <= '0;
			pkts_q  <= '0;
			words_q <= '0;
			held_q  <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			lines_q <= lines_d;
			row_q   <= row_d;
			col_q   <= col_d;
			pkts_q  <= pkts_d;
			words_q <= words_d;
			held_q  <= held_d;
		end
	end

	`ASSERT_CLK(a_count_nonzero, clk, arst_n, (res_valid && !res.end_of_chunk) |-> (res.word_count != 8'd0), "write command without words")
	`ASSERT_CLK(a_bare_is_clean, clk, arst_n, (res_valid && res.word_count == 8'd0) |-> (res.column == 16'd0 && res.pixel_first == 8'd0 && res.pixel_second == 8'd0 && res.end_of_chunk), "bare marker with payload")
	`ASSERT_NEVER(a_quiet_when_done, clk, arst_n, phase_q == PH_DONE && !chunk_start && res_valid, "command after chunk end")
	`ASSERT_CLK(a_end_parks, clk, arst_n, (take && res_valid && res.end_of_chunk) |=> (phase_q == PH_DONE), "parser not parked after chunk end")

endmodule

`default_nettype wire

// ===== rtl/core/fwd_out_reg.sv =====
// Result register of the word-delta decoder: holds one write command until
// the sink takes it. Depends on fwd_pkg and fwd_out_if.
`default_nettype none

module fwd_out_reg
	import fwd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire fwd_result_t res,
	output logic             space,
	fwd_out_if.source        cmd
);

	logic        valid_q;
	fwd_result_t data_q;

	// A new command may enter when the register is empty or is being drained.
	assign space = !valid_q || cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (cmd.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign cmd.valid        = valid_q;
	assign cmd.row          = data_q.row;
	assign cmd.column       = data_q.column;
	assign cmd.pixel_first  = data_q.pixel_first;
	assign cmd.pixel_second = data_q.pixel_second;
	assign cmd.word_count   = data_q.word_count;
	assign cmd.end_of_chunk = data_q.end_of_chunk;

endmodule

`default_nettype wire

// ===== rtl/core/flic_word_delta_decoder.sv =====
// Top level of the word-delta (SS2) chunk decoder.
// Depends on fwd_pkg, fwd_in_if, fwd_out_if, fwd_parser and fwd_out_reg.
//
//   channel   direction  request contents
//   payload   in         data_byte, chunk_start (one chunk payload byte)
//   cmd       out        row, column, pixel_first, pixel_second, word_count,
//                        end_of_chunk (one frame-store write command)
//
// One payload byte is taken per clock cycle unless the result register stalls; its
// command, if any, appears in the result register on the following cycle.
// The byte rate is set by the result register: a byte is refused only while a
// command sits there and the sink does not take it in the same cycle.
// The asynchronous reset leaves the parser awaiting the low byte of a line
// count and the result register empty.
// A stall on the command side holds both the command and the parse state.
`default_nettype none

module flic_word_delta_decoder
	import fwd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	fwd_in_if.sink    payload,
	fwd_out_if.source cmd
);

	logic        space;
	logic        take;
	logic        res_valid;
	fwd_result_t res;

	// A byte is accepted whenever the result register can take what it makes.
	assign payload.ready = space;
	assign take          = payload.valid && space;

	// Parse state advances once per accepted byte; the resulting command,
	// when there is one, is built in the same cycle.
	fwd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.data_byte   (payload.data_byte),
		.chunk_start (payload.chunk_start),
		.res_valid   (res_valid),
		.res         (res)
	);

	// The result register separates the command sink from the byte source.
	fwd_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (take && res_valid),
		.res    (res),
		.space  (space),
		.cmd    (cmd)
	);

endmodule

`default_nettype wire

// ===== tb/flic_word_delta_decoder_test.sv =====
// Self-checking bench for the word-delta (SS2) chunk decoder top level.
// Depends on fwd_pkg, fwd_in_if, fwd_out_if and flic_word_delta_decoder; the bench
// predicts every write command from the payload bytes it sends.
`default_nettype none

module flic_word_delta_decoder_test;
	import fwd_pkg::*;

	// Parse position of the bench's own decoder, one value per expected byte kind.
	typedef enum logic [3:0] {
		AWAIT_LINES_LO,
		AWAIT_LINES_HI,
		AWAIT_WORD_LO,
		AWAIT_WORD_HI,
		AWAIT_SKIP,
		AWAIT_COUNT,
		AWAIT_LIT_LO,
		AWAIT_LIT_HI,
		AWAIT_FILL_LO,
		AWAIT_FILL_HI,
		CHUNK_DONE
	} parse_t;

	// One payload request as queued for the driver.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       chunk_start;
	} payload_req_t;

	localparam int TIMEOUT_UNITS = 3_200_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// The bench drives the channels through these local copies so that every
	// input of the block is known from time zero.
	logic       in_valid = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       in_start = 1'b0;
	logic       out_ready = 1'b0;
	logic       hold_off = 1'b0;

	fwd_in_if  payload_ch ();
	fwd_out_if cmd_ch ();

	assign payload_ch.valid       = in_valid;
	assign payload_ch.data_byte   = in_byte;
	assign payload_ch.chunk_start = in_start;
	assign cmd_ch.ready           = out_ready;

	flic_word_delta_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.payload(payload_ch),
		.cmd    (cmd_ch)
	);

	always #4 clk = ~clk;

	payload_req_t pending_reqs[$];
	fwd_result_t  expected_cmds[$];
	int           errors = 0;
	int           accepted_bytes = 0;
	int           send_gap = 0;
	int           send_calm = 0;
	int           recv_stall = 0;
	int           recv_calm = 0;

	// State of the bench's decoder; it mirrors what the block keeps between bytes.
	parse_t      phase;
	logic [15:0] lines_todo;
	logic [15:0] row_pos;
	logic [15:0] col_pos;
	logic [15:0] packets_todo;
	logic [7:0]  words_todo;
	logic [7:0]  low_byte;

	task automatic reset_parser();
		phase        = AWAIT_LINES_LO;
		lines_todo   = '0;
		row_pos      = '0;
		col_pos      = '0;
		packets_todo = '0;
		words_todo   = '0;
		low_byte     = '0;
	endtask

	// Closes the current line; true when it was the last line of the chunk.
	function automatic bit finish_line();
		row_pos    = row_pos + 16'd1;
		col_pos    = '0;
		lines_todo = lines_todo - 16'd1;
		if (lines_todo == 16'd0) begin
			phase = CHUNK_DONE;
			return 1'b1;
		end
		phase = AWAIT_WORD_LO;
		return 1'b0;
	endfunction

	// Closes the current packet; true when that also closed the chunk.
	function automatic bit finish_packet();
		packets_todo = packets_todo - 16'd1;
		if (packets_todo == 16'd0)
			return finish_line();
		phase = AWAIT_SKIP;
		return 1'b0;
	endfunction

	// Advances the bench's decoder by one accepted payload byte and queues the
	// write command that the byte causes, if any.
	task automatic decode_byte(input logic [7:0] b, input logic start);
		logic [15:0] w;
		fwd_result_t c;
		c = '0;
		if (start)
			reset_parser();
		case (phase)
			AWAIT_LINES_LO: begin
				low_byte = b;
				phase = AWAIT_LINES_HI;
			end
			AWAIT_LINES_HI: begin
				lines_todo = {b, low_byte};
				if (lines_todo == 16'd0) begin
					// An empty chunk still announces its end with a bare marker.
					phase = CHUNK_DONE;
					c.row = row_pos;
					c.end_of_chunk = 1'b1;
					expected_cmds.push_back(c);
				end else begin
					phase = AWAIT_WORD_LO;
				end
			end
			AWAIT_WORD_LO: begin
				low_byte = b;
				phase = AWAIT_WORD_HI;
			end
			AWAIT_WORD_HI: begin
				w = {b, low_byte};
				if (w[15:14] == LINE_WORD_SKIP) begin
					// Row skip: the negated word, modulo 65536, is added to the row.
					row_pos = row_pos - w;
					phase = AWAIT_WORD_LO;
				end else if (w[15:14] != LINE_WORD_COUNT) begin
					phase = AWAIT_WORD_LO;
				end else begin
					packets_todo = w;
					if (w == 16'd0) begin
						c.row = row_pos;
						if (finish_line()) begin
							c.end_of_chunk = 1'b1;
							expected_cmds.push_back(c);
						end
					end else begin
						phase = AWAIT_SKIP;
					end
				end
			end
			AWAIT_SKIP: begin
				col_pos = col_pos + 16'(b);
				phase = AWAIT_COUNT;
			end
			AWAIT_COUNT: begin
				if (b == 8'd0) begin
					c.row = row_pos;
					if (finish_packet()) begin
						c.end_of_chunk = 1'b1;
						expected_cmds.push_back(c);
					end
				end else if (b[7] == 1'b0) begin
					words_todo = b;
					phase = AWAIT_LIT_LO;
				end else begin
					// The negated count byte is the run length; 0x80 gives 128.
					words_todo = 8'd0 - b;
					phase = AWAIT_FILL_LO;
				end
			end
			AWAIT_LIT_LO: begin
				low_byte = b;
				phase = AWAIT_LIT_HI;
			end
			AWAIT_LIT_HI: begin
				c.row = row_pos;
				c.column = col_pos;
				c.pixel_first = low_byte;
				c.pixel_second = b;
				c.word_count = 8'd1;
				col_pos = col_pos + 16'd2;
				words_todo = words_todo - 8'd1;
				if (words_todo == 8'd0)
					c.end_of_chunk = finish_packet();
				else
					phase = AWAIT_LIT_LO;
				expected_cmds.push_back(c);
			end
			AWAIT_FILL_LO: begin
				low_byte = b;
				phase = AWAIT_FILL_HI;
			end
			AWAIT_FILL_HI: begin
				c.row = row_pos;
				c.column = col_pos;
				c.pixel_first = low_byte;
				c.pixel_second = b;
				c.word_count = words_todo;
				col_pos = col_pos + {7'd0, words_todo, 1'b0};
				words_todo = '0;
				c.end_of_chunk = finish_packet();
				expected_cmds.push_back(c);
			end
			default: begin
				// Bytes after the end of a chunk are dropped until the next start.
			end
		endcase
	endtask

	// Idle length for either side: mostly none, some short, a few long, and now
	// and then a calm stretch with no idling at all.
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic start);
		payload_req_t q;
		q.data_byte = b;
		q.chunk_start = start;
		pending_reqs.push_back(q);
	endtask

	// Payload words travel low byte first.
	task automatic push_word(input logic [15:0] w);
		push_byte(w[7:0], 1'b0);
		push_byte(w[15:8], 1'b0);
	endtask

	// Appends one chunk with random content. A broken chunk loses its tail, so
	// that the next chunk start has to restart the parser mid-way.
	task automatic add_chunk(input bit broken);
		int nlines;
		int npk;
		int kind;
		int nw;
		int mag;
		int first;
		int added;
		logic [15:0] lw;
		first = pending_reqs.size();
		nlines = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
		push_byte(nlines[7:0], 1'b1);
		push_byte(nlines[15:8], 1'b0);
		for (int l = 0; l < nlines; l++) begin
			// Occasional row skips and ignored line words ahead of the packet count.
			while ($urandom_range(0, 3) == 0) begin
				lw = 16'($urandom());
				if (lw[15:14] == LINE_WORD_COUNT)
					lw[15:14] = LINE_WORD_SKIP;
				push_word(lw);
			end
			npk = $urandom_range(0, 3);
			push_word(16'(npk));
			for (int p = 0; p < npk; p++) begin
				push_byte(8'($urandom()), 1'b0);
				kind = $urandom_range(0, 9);
				if (kind == 0) begin
					push_byte(8'h00, 1'b0);
				end else if (kind <= 6) begin
					nw = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 127)
						: $urandom_range(1, 4);
					push_byte(8'(nw), 1'b0);
					repeat (nw) push_word(16'($urandom()));
				end else begin
					mag = ($urandom_range(0, 9) == 0) ? 128 : $urandom_range(1, 127);
					push_byte(8'(256 - mag), 1'b0);
					push_word(16'($urandom()));
				end
			end
		end
		added = pending_reqs.size() - first;
		if (broken) begin
			repeat ($urandom_range(1, (added > 8) ? 8 : added - 1))
				void'(pending_reqs.pop_back());
		end else if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 2)) push_byte(8'($urandom()), 1'b0);
		end
	endtask

	// Sender: a new request is offered once the previous one has been taken,
	// after a random gap. Each accepted byte goes through the predictor at once.
	always @(posedge clk) begin
		payload_req_t q;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || payload_ch.ready) begin
			if (in_valid) begin
				decode_byte(in_byte, in_start);
				accepted_bytes++;
			end
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				q = pending_reqs.pop_front();
				in_byte  <= q.data_byte;
				in_start <= q.chunk_start;
				in_valid <= 1'b1;
				send_gap = pick_gap(send_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: ready drops for random stalls, and for the long hold-off below.
	always @(posedge clk) begin
		if (!arst_n || hold_off) begin
			out_ready <= 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			recv_stall = pick_gap(recv_calm);
		end
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endtask

	// Monitor: every command taken from the block is matched against the oldest
	// prediction.
	always @(posedge clk) begin
		fwd_result_t want;
		if (arst_n && cmd_ch.valid && out_ready) begin
			if (expected_cmds.size() == 0) begin
				$error("unexpected command: row %0d column %0d count %0d",
					cmd_ch.row, cmd_ch.column, cmd_ch.word_count);
				errors++;
			end else begin
				want = expected_cmds.pop_front();
				check_field("row", want.row, cmd_ch.row);
				check_field("column", want.column, cmd_ch.column);
				check_field("pixel_first", want.pixel_first, cmd_ch.pixel_first);
				check_field("pixel_second", want.pixel_second, cmd_ch.pixel_second);
				check_field("word_count", want.word_count, cmd_ch.word_count);
				check_field("end_of_chunk", want.end_of_chunk, cmd_ch.end_of_chunk);
			end
		end
	end

	// Back-pressure: the receiver refuses commands for a long stretch while the
	// sender keeps offering, so the result register fills and the input stalls.
	initial begin
		while (accepted_bytes < 400)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#(TIMEOUT_UNITS);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int r;
		reset_parser();

		// Straight after reset the parser awaits a line count even without a chunk
		// start: one line, one packet, skip 255, one literal word of 0x00 and 0xff.
		push_byte(8'h01, 1'b0);
		push_byte(8'h00, 1'b0);
		push_word(16'h0001);
		push_byte(8'hff, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hff, 1'b0);

		// Zero line count gives a bare end marker; the byte after it is ignored.
		push_byte(8'h00, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'haa, 1'b0);

		// Two lines: a row skip, both ignored line word kinds and an empty line,
		// then a fill of 128 and a packet of count zero that ends the chunk with
		// a bare marker.
		push_byte(8'h02, 1'b1);
		push_byte(8'h00, 1'b0);
		push_word(16'hfffe);
		push_word(16'h4000);
		push_word(16'h8000);
		push_word(16'h0000);
		push_word(16'h0002);
		push_byte(8'h00, 1'b0);
		push_byte(8'h80, 1'b0);
		push_word(16'h00ff);
		push_byte(8'h03, 1'b0);
		push_byte(8'h00, 1'b0);

		// Random part: mostly well-formed chunks, some cut short, some noise.
		while (pending_reqs.size() < 1450) begin
			r = $urandom_range(0, 9);
			if (r < 8) begin
				add_chunk(1'b0);
			end else if (r == 8) begin
				add_chunk(1'b1);
			end else begin
				repeat ($urandom_range(4, 12))
					push_byte(8'($urandom()), ($urandom_range(0, 7) == 0));
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || in_valid || expected_cmds.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/fwd_pkg.sv
rtl/core/fwd_in_if.sv
rtl/core/fwd_out_if.sv
rtl/core/fwd_parser.sv
rtl/core/fwd_out_reg.sv
rtl/core/flic_word_delta_decoder.sv
tb/flic_word_delta_decoder_test.sv
